@@ hw/rtl/u8vc_pkg.sv @@
// Package: payload types and code point limits for the UTF-8 validate and count unit.
`default_nettype none

package u8vc_pkg;

   localparam int unsigned CP_WIDTH  = 21;
   localparam int unsigned OUT_WIDTH = 16;

   localparam logic [CP_WIDTH-1:0]  CP_TWO_BYTE_MIN   = 21'h00_0080;
   localparam logic [CP_WIDTH-1:0]  CP_THREE_BYTE_MIN = 21'h00_0800;
   localparam logic [CP_WIDTH-1:0]  CP_FOUR_BYTE_MIN  = 21'h01_0000;
   localparam logic [CP_WIDTH-1:0]  CP_BMP_MAX        = 21'h00_FFFF;
   localparam logic [CP_WIDTH-1:0]  CP_MAX            = 21'h10_FFFF;
   localparam logic [CP_WIDTH-1:0]  CP_SURROGATE_LO   = 21'h00_D800;
   localparam logic [CP_WIDTH-1:0]  CP_SURROGATE_HI   = 21'h00_DFFF;
   localparam logic [OUT_WIDTH-1:0] OUT_MAX           = 16'hFFFF;

   localparam logic [2:0] SEQ_LEN_ONE   = 3'd1;
   localparam logic [2:0] SEQ_LEN_TWO   = 3'd2;
   localparam logic [2:0] SEQ_LEN_THREE = 3'd3;
   localparam logic [2:0] SEQ_LEN_FOUR  = 3'd4;

   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } u8vc_req_type;

   typedef struct packed {
      logic                 valid_res;
      logic [OUT_WIDTH-1:0] scalar_count;
      logic [OUT_WIDTH-1:0] utf16_count;
   } u8vc_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/utf8_validate_and_count_unit.sv @@
// UTF-8 validate and count unit: per-byte decode, running counts, one result per string.
//
//   channel | direction | payload                                   | handshake
//   req     | in        | data_byte, is_last                        | req_valid / req_ready
//   rsp     | out       | valid_res, scalar_count, utf16_count      | rsp_valid / rsp_ready
//
// One byte per cycle while req_ready is high; decode of a byte is short combinational
// logic from the decode state registers into those registers and the result register.
// A string of N bytes gives its result in the cycle after its last byte is accepted.
// Reset clears decode state, counts and the result valid.
// req_ready drops only while a result waits and rsp_ready is low.
`default_nettype none

module utf8_validate_and_count_unit #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire u8vc_pkg::u8vc_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output u8vc_pkg::u8vc_rsp_type      rsp_payload
);

   localparam int unsigned XW = COUNT_WIDTH + u8vc_pkg::OUT_WIDTH;

   logic [1:0]                      pending_ff, pending_in;
   logic [2:0]                      seq_len_ff, seq_len_in;
   logic [u8vc_pkg::CP_WIDTH-1:0]   partial_ff, partial_in;
   logic                            err_ff, err_in;
   logic [COUNT_WIDTH-1:0]          scalars_ff, scalars_in;
   logic [COUNT_WIDTH-1:0]          units_ff, units_in;
   logic                            rsp_valid_ff;
   u8vc_pkg::u8vc_rsp_type          rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic                            finish;
   logic                            bad;
   logic [u8vc_pkg::CP_WIDTH-1:0]   fin_cp;
   logic [2:0]                      fin_len;
   logic [COUNT_WIDTH:0]            scalar_sum;
   logic [COUNT_WIDTH:0]            unit_sum;
   logic [XW-1:0]                   scalars_x;
   logic [XW-1:0]                   units_x;
   logic                            ok;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      pending_in = pending_ff;
      seq_len_in = seq_len_ff;
      partial_in = partial_ff;
      err_in     = err_ff;
      scalars_in = scalars_ff;
      units_in   = units_ff;
      finish     = 1'b0;
      fin_cp     = '0;
      fin_len    = '0;
      bad        = 1'b0;
      scalar_sum = '0;
      unit_sum   = '0;
      if (!err_ff) begin
         if (pending_ff == 2'd0) begin
            case (req_payload.data_byte) inside
               [8'h00:8'h7F]: begin
                  finish  = 1'b1;
                  fin_cp  = {14'b0, req_payload.data_byte[6:0]};
                  fin_len = u8vc_pkg::SEQ_LEN_ONE;
               end
               [8'hC0:8'hDF]: begin
                  seq_len_in = u8vc_pkg::SEQ_LEN_TWO;
                  pending_in = 2'd1;
                  partial_in = {16'b0, req_payload.data_byte[4:0]};
               end
               [8'hE0:8'hEF]: begin
                  seq_len_in = u8vc_pkg::SEQ_LEN_THREE;
                  pending_in = 2'd2;
                  partial_in = {17'b0, req_payload.data_byte[3:0]};
               end
               [8'hF0:8'hF7]: begin
                  seq_len_in = u8vc_pkg::SEQ_LEN_FOUR;
                  pending_in = 2'd3;
                  partial_in = {18'b0, req_payload.data_byte[2:0]};
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end else if (req_payload.data_byte[7:6] != u8vc_pkg::CONT_TAG) begin
            err_in = 1'b1;
         end else begin
            partial_in = {partial_ff[14:0], req_payload.data_byte[5:0]};
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               finish  = 1'b1;
               fin_cp  = {partial_ff[14:0], req_payload.data_byte[5:0]};
               fin_len = seq_len_ff;
            end
         end
      end
      if (finish) begin
         bad = (fin_len == u8vc_pkg::SEQ_LEN_TWO   && fin_cp < u8vc_pkg::CP_TWO_BYTE_MIN)   ||
               (fin_len == u8vc_pkg::SEQ_LEN_THREE && fin_cp < u8vc_pkg::CP_THREE_BYTE_MIN) ||
               (fin_len == u8vc_pkg::SEQ_LEN_FOUR  && fin_cp < u8vc_pkg::CP_FOUR_BYTE_MIN)  ||
               (fin_cp > u8vc_pkg::CP_MAX) ||
               (fin_cp >= u8vc_pkg::CP_SURROGATE_LO && fin_cp <= u8vc_pkg::CP_SURROGATE_HI) ||
               (fin_cp == '0);
         if (bad) begin
            err_in = 1'b1;
         end else begin
            scalar_sum = {1'b0, scalars_ff} + (COUNT_WIDTH+1)'(1);
            unit_sum   = {1'b0, units_ff} +
                         ((fin_cp > u8vc_pkg::CP_BMP_MAX) ? (COUNT_WIDTH+1)'(2)
                                                          : (COUNT_WIDTH+1)'(1));
            scalars_in = scalar_sum[COUNT_WIDTH] ? '1 : scalar_sum[COUNT_WIDTH-1:0];
            units_in   = unit_sum[COUNT_WIDTH]   ? '1 : unit_sum[COUNT_WIDTH-1:0];
         end
      end
   end

   assign ok        = !err_in && (pending_in == 2'd0);
   assign scalars_x = XW'(scalars_in);
   assign units_x   = XW'(units_in);

   always_comb begin
      rsp_data_in.valid_res    = ok;
      rsp_data_in.scalar_count = '0;
      rsp_data_in.utf16_count  = '0;
      if (ok) begin
         rsp_data_in.scalar_count = (scalars_x > XW'(u8vc_pkg::OUT_MAX)) ?
                                    u8vc_pkg::OUT_MAX : scalars_x[u8vc_pkg::OUT_WIDTH-1:0];
         rsp_data_in.utf16_count  = (units_x > XW'(u8vc_pkg::OUT_MAX)) ?
                                    u8vc_pkg::OUT_MAX : units_x[u8vc_pkg::OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         seq_len_ff <= '0;
         partial_ff <= '0;
         err_ff     <= 1'b0;
         scalars_ff <= '0;
         units_ff   <= '0;
      end else if (accept) begin
         if (req_payload.is_last) begin
            pending_ff <= '0;
            seq_len_ff <= '0;
            partial_ff <= '0;
            err_ff     <= 1'b0;
            scalars_ff <= '0;
            units_ff   <= '0;
         end else begin
            pending_ff <= pending_in;
            seq_len_ff <= seq_len_in;
            partial_ff <= partial_in;
            err_ff     <= err_in;
            scalars_ff <= scalars_in;
            units_ff   <= units_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_payload.is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.is_last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while a result is stalled");

   a_invalid_zero_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.valid_res |->
         rsp_data_ff.scalar_count == '0 && rsp_data_ff.utf16_count == '0)
      else $error("invalid result carries nonzero counts");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.is_last |=>
         pending_ff == 2'd0 && !err_ff && scalars_ff == '0 && units_ff == '0)
      else $error("decode state not cleared after end of string");

   a_pending_matches_len: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd0 |-> seq_len_ff > {1'b0, pending_ff})
      else $error("pending count disagrees with sequence length");

   a_units_cover_scalars: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.valid_res |->
         rsp_data_ff.utf16_count >= rsp_data_ff.scalar_count)
      else $error("UTF-16 unit count below scalar count");

endmodule

`default_nettype wire

@@ sim/tb_utf8_validate_and_count_unit.sv @@
// Testbench for the UTF-8 validate and count unit: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_utf8_validate_and_count_unit;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;
   typedef enum {
      FAULT_NONE, FAULT_OVERLONG, FAULT_SURROGATE, FAULT_ABOVE_MAX, FAULT_NUL,
      FAULT_BAD_LEAD, FAULT_BAD_CONT, FAULT_TRUNCATE, FAULT_NOISE
   } fault_type;

   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 20;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   u8vc_pkg::u8vc_req_type req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   u8vc_pkg::u8vc_rsp_type rsp_payload;

   utf8_validate_and_count_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("tb: failure");
      $finish;
   end

   // decoder copy and expected string verdicts
   logic [1:0]   dec_pending = '0;
   logic [2:0]   dec_len = '0;
   logic [20:0]  dec_cp = '0;
   logic         dec_err = 1'b0;
   logic [15:0]  scalar_tally = '0;
   logic [15:0]  unit_tally = '0;
   u8vc_pkg::u8vc_rsp_type string_verdicts[$];

   logic [7:0]   str_bytes[$];
   int           mismatches = 0;
   int           bytes_sent = 0;
   int           strings_checked = 0;
   int           valid_strings = 0;
   int           burst_left = 0;
   bit           gaps_on = 1'b1;
   rx_mode_type  rx_mode = RX_RANDOM;
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;
   logic [15:0]  stall_pattern = 16'hA5C3;
   int           pattern_age = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb: mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   function automatic logic [15:0] sat_add(input logic [15:0] a, input int unsigned n);
      int unsigned s;
      s = a + n;
      return (s > u8vc_pkg::OUT_MAX) ? u8vc_pkg::OUT_MAX : 16'(s);
   endfunction

   task automatic close_scalar(input logic [20:0] cp, input logic [2:0] len);
      logic bad;
      bad = (len == u8vc_pkg::SEQ_LEN_TWO && cp < u8vc_pkg::CP_TWO_BYTE_MIN) ||
            (len == u8vc_pkg::SEQ_LEN_THREE && cp < u8vc_pkg::CP_THREE_BYTE_MIN) ||
            (len == u8vc_pkg::SEQ_LEN_FOUR && cp < u8vc_pkg::CP_FOUR_BYTE_MIN) ||
            cp > u8vc_pkg::CP_MAX ||
            (cp >= u8vc_pkg::CP_SURROGATE_LO && cp <= u8vc_pkg::CP_SURROGATE_HI) ||
            cp == '0;
      if (bad) begin
         dec_err = 1'b1;
      end else begin
         scalar_tally = sat_add(scalar_tally, 1);
         unit_tally = sat_add(unit_tally, (cp > u8vc_pkg::CP_BMP_MAX) ? 2 : 1);
      end
   endtask

   task automatic track_utf8_byte(input logic [7:0] b, input logic last);
      logic [2:0]             len;
      logic [20:0]            lead_bits;
      u8vc_pkg::u8vc_rsp_type want;
      len = '0;
      lead_bits = '0;
      if (!dec_err) begin
         if (dec_pending == 0) begin
            if (b[7] == 1'b0) begin
               len = u8vc_pkg::SEQ_LEN_ONE;
               lead_bits = {14'd0, b[6:0]};
            end else if (b[7:5] == 3'b110) begin
               len = u8vc_pkg::SEQ_LEN_TWO;
               lead_bits = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
               len = u8vc_pkg::SEQ_LEN_THREE;
               lead_bits = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
               len = u8vc_pkg::SEQ_LEN_FOUR;
               lead_bits = {18'd0, b[2:0]};
            end else begin
               dec_err = 1'b1;
            end
            if (len == u8vc_pkg::SEQ_LEN_ONE) begin
               close_scalar(lead_bits, len);
            end else if (!dec_err) begin
               dec_len = len;
               dec_pending = 2'(len - 3'd1);
               dec_cp = lead_bits;
            end
         end else if (b[7:6] != u8vc_pkg::CONT_TAG) begin
            dec_err = 1'b1;
         end else begin
            dec_cp = {dec_cp[14:0], b[5:0]};
            dec_pending = dec_pending - 2'd1;
            if (dec_pending == 0)
               close_scalar(dec_cp, dec_len);
         end
      end
      if (last) begin
         want.valid_res = !dec_err && dec_pending == 0;
         want.scalar_count = want.valid_res ? scalar_tally : '0;
         want.utf16_count = want.valid_res ? unit_tally : '0;
         string_verdicts.push_back(want);
         dec_pending = '0;
         dec_len = '0;
         dec_cp = '0;
         dec_err = 1'b0;
         scalar_tally = '0;
         unit_tally = '0;
      end
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic last);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_payload.data_byte = b;
      req_payload.is_last = last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      track_utf8_byte(b, last);
      bytes_sent++;
      if (burst_left > 0)
         burst_left--;
   endtask

   task automatic send_string();
      foreach (str_bytes[i])
         offer_byte(str_bytes[i], i == str_bytes.size() - 1);
      str_bytes.delete();
   endtask

   function automatic logic [2:0] len_for(input logic [20:0] cp);
      if (cp < u8vc_pkg::CP_TWO_BYTE_MIN) return u8vc_pkg::SEQ_LEN_ONE;
      if (cp < u8vc_pkg::CP_THREE_BYTE_MIN) return u8vc_pkg::SEQ_LEN_TWO;
      if (cp < u8vc_pkg::CP_FOUR_BYTE_MIN) return u8vc_pkg::SEQ_LEN_THREE;
      return u8vc_pkg::SEQ_LEN_FOUR;
   endfunction

   task automatic emit_cp(input logic [20:0] cp, input logic [2:0] len);
      case (len)
         u8vc_pkg::SEQ_LEN_ONE: str_bytes.push_back({1'b0, cp[6:0]});
         u8vc_pkg::SEQ_LEN_TWO: begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({u8vc_pkg::CONT_TAG, cp[5:0]});
         end
         u8vc_pkg::SEQ_LEN_THREE: begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({u8vc_pkg::CONT_TAG, cp[11:6]});
            str_bytes.push_back({u8vc_pkg::CONT_TAG, cp[5:0]});
         end
         default: begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({u8vc_pkg::CONT_TAG, cp[17:12]});
            str_bytes.push_back({u8vc_pkg::CONT_TAG, cp[11:6]});
            str_bytes.push_back({u8vc_pkg::CONT_TAG, cp[5:0]});
         end
      endcase
   endtask

   function automatic logic [20:0] pick_scalar(input logic [2:0] len);
      logic [20:0] edges[10];
      logic [20:0] cp;
      edges = '{21'h1, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000,
                21'hFFFF, 21'h10000, 21'h10FFFF};
      if ($urandom_range(0, 7) == 0 && len == '0)
         return edges[$urandom_range(0, 9)];
      case (len == '0 ? 3'($urandom_range(1, 4)) : len)
         u8vc_pkg::SEQ_LEN_ONE: cp = 21'($urandom_range(1, 'h7F));
         u8vc_pkg::SEQ_LEN_TWO: cp = 21'($urandom_range('h80, 'h7FF));
         u8vc_pkg::SEQ_LEN_THREE: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= u8vc_pkg::CP_SURROGATE_LO && cp <= u8vc_pkg::CP_SURROGATE_HI)
               cp = cp - 21'h800;
         end
         default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      return cp;
   endfunction

   task automatic emit_fault(input fault_type fk);
      logic [2:0]  len;
      logic [20:0] cp;
      logic [7:0]  b;
      int          base;
      len = 3'($urandom_range(2, 4));
      case (fk)
         FAULT_OVERLONG: begin
            case (len)
               u8vc_pkg::SEQ_LEN_TWO: cp = 21'($urandom_range(0, 'h7F));
               u8vc_pkg::SEQ_LEN_THREE: cp = 21'($urandom_range(0, 'h7FF));
               default: cp = 21'($urandom_range(0, 'hFFFF));
            endcase
            emit_cp(cp, len);
         end
         FAULT_SURROGATE:
            emit_cp(21'($urandom_range('hD800, 'hDFFF)), u8vc_pkg::SEQ_LEN_THREE);
         FAULT_ABOVE_MAX:
            emit_cp(21'($urandom_range('h110000, 'h1FFFFF)), u8vc_pkg::SEQ_LEN_FOUR);
         FAULT_NUL: str_bytes.push_back(8'h00);
         FAULT_BAD_LEAD: begin
            if ($urandom_range(0, 1) == 0)
               str_bytes.push_back(8'($urandom_range('h80, 'hBF)));
            else
               str_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
         end
         FAULT_BAD_CONT: begin
            base = str_bytes.size();
            emit_cp(pick_scalar(len), len);
            do b = 8'($urandom_range(0, 255)); while (b[7:6] == u8vc_pkg::CONT_TAG);
            str_bytes[base + $urandom_range(1, len - 1)] = b;
         end
         default: begin
            emit_cp(pick_scalar(len), len);
            repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
         end
      endcase
   endtask

   task automatic build_string();
      fault_type   fk;
      int          n;
      int          fpos;
      logic [20:0] cp;
      fk = ($urandom_range(0, 9) < 7) ? FAULT_NONE : fault_type'($urandom_range(1, 8));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      fpos = $urandom_range(0, n - 1);
      if (fk == FAULT_NOISE) begin
         repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         for (int i = 0; i < n; i++) begin
            if (fk != FAULT_NONE && fk != FAULT_TRUNCATE && i == fpos) begin
               emit_fault(fk);
            end else begin
               cp = pick_scalar('0);
               emit_cp(cp, len_for(cp));
            end
         end
         if (fk == FAULT_TRUNCATE)
            emit_fault(fk);
      end
   endtask

   task automatic test_directed_cases();
      gaps_on = 1'b1;
      rx_mode = RX_RANDOM;
      str_bytes = {8'h41};                       send_string();
      str_bytes = {8'h00};                       send_string();
      str_bytes = {8'hFF};                       send_string();
      str_bytes = {8'h80};                       send_string();
      str_bytes = {8'hC0, 8'h80};                send_string();
      str_bytes = {8'hE2, 8'h82};                send_string();
      str_bytes = {8'hED, 8'hA0, 8'h80};         send_string();
      str_bytes = {8'hF4, 8'h90, 8'h80, 8'h80};  send_string();
      str_bytes = {8'hC3, 8'h41};                send_string();
      str_bytes = {8'hFF, 8'h41, 8'hC3, 8'hA9};  send_string();
      str_bytes = {8'hF0, 8'h9F, 8'h98, 8'h80};  send_string();
   endtask

   task automatic test_random_strings(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      gaps_on = 1'b1;
      while (bytes_sent < stop_at) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         build_string();
         send_string();
      end
   endtask

   task automatic test_receiver_hold(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      gaps_on = 1'b0;
      rx_mode = RX_ALWAYS;
      hold_requests++;
      while (bytes_sent < stop_at) begin
         build_string();
         send_string();
      end
   endtask

   task automatic test_back_to_back(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      gaps_on = 1'b0;
      rx_mode = RX_ALWAYS;
      while (bytes_sent < stop_at) begin
         build_string();
         send_string();
      end
   endtask

   always @(negedge clock) begin
      pattern_age++;
      if (pattern_age == 48) begin
         pattern_age = 0;
         stall_pattern = 16'($urandom_range(1, 'hFFFF));
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready = 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_ready = 1'b1;
            RX_RANDOM: rsp_ready = ($urandom_range(0, 99) < 65);
            default: begin
               rsp_ready = stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
         endcase
      end
   end

   always @(posedge clock) begin
      u8vc_pkg::u8vc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (string_verdicts.size() == 0) begin
            report_mismatch("result with nothing expected, valid_res", rsp_payload.valid_res, 0);
         end else begin
            want = string_verdicts.pop_front();
            strings_checked++;
            if (want.valid_res)
               valid_strings++;
            if (rsp_payload.valid_res !== want.valid_res)
               report_mismatch("valid_res", rsp_payload.valid_res, want.valid_res);
            if (rsp_payload.scalar_count !== want.scalar_count)
               report_mismatch("scalar_count", rsp_payload.scalar_count, want.scalar_count);
            if (rsp_payload.utf16_count !== want.utf16_count)
               report_mismatch("utf16_count", rsp_payload.utf16_count, want.utf16_count);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_random_strings(1150);
      test_receiver_hold(150);
      test_back_to_back(250);
      @(negedge clock);
      req_valid = 1'b0;
      rx_mode = RX_RANDOM;
      while (string_verdicts.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (string_verdicts.size() != 0)
         report_mismatch("expected results left over", string_verdicts.size(), 0);
      $display("tb: %0d bytes sent, %0d strings checked (%0d valid)",
               bytes_sent, strings_checked, valid_strings);
      $display("tb: covered malformed input, receiver stalls and a long hold with input backed up");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
